// ===== rtl/core/rtttl_pkg.sv =====
// ----------------------------------------------------------------------------
// RTTTL parser package
// Word types, character codes and constants shared by the parser core.
// ----------------------------------------------------------------------------
package rtttl_pkg;

    localparam logic [3:0]  OCT_OFFSET    = 4'd0;
    localparam logic [19:0] ACCUM_MAX     = 20'd65535;
    localparam int          MS_PER_MIN    = 60000;
    localparam int          BPM_DEFAULT   = 63;
    localparam int          BEATS_PER_BAR = 4;
    localparam logic [17:0] WHOLE_DEFAULT = 18'((MS_PER_MIN / BPM_DEFAULT) * BEATS_PER_BAR);
    localparam logic [17:0] WHOLE_DIVIDEND = 18'(MS_PER_MIN);
    localparam logic [15:0] LEN_DEFAULT   = 16'd4;
    localparam logic [3:0]  OCT_DEFAULT   = 4'd6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_G  = 8'h67;
    localparam logic [7:0] CH_LC_O  = 8'h6F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } item_word_t;

    typedef struct packed {
        logic [3:0]  semitone;
        logic [3:0]  octave;
        logic [18:0] duration_ms;
        logic        tempo_error;
        logic        last_note;
    } note_word_t;

    function automatic logic [3:0] letter_code(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            CH_LC_C: code = 4'd1;
            CH_LC_D: code = 4'd3;
            CH_LC_E: code = 4'd5;
            CH_LC_F: code = 4'd6;
            CH_LC_G: code = 4'd8;
            CH_LC_A: code = 4'd10;
            CH_LC_B: code = 4'd12;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/rtttl_ringtone_parser_core.sv =====
// ----------------------------------------------------------------------------
// RTTTL ringtone parser core
// Parses ringtone text one character word at a time and emits note words.
// ----------------------------------------------------------------------------
// Sequencing: an accepted character passes S_DIV (for a tempo field end or
//   a note letter, using the 18-step shared restoring divider) and S_FIN,
//   which loads the note word; no new character is taken until S_IDLE.
// Reset: asynchronous, active low; parser returns to name skipping with
//   default length 4, octave 6, and no note word pending.
module rtttl_ringtone_parser_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  rtttl_pkg::item_word_t item_word,
    output logic                 note_valid,
    input  logic                 note_stall,
    output rtttl_pkg::note_word_t note_word
);
    import rtttl_pkg::*;

    localparam logic [3:0] PH_NAME    = 4'd0;
    localparam logic [3:0] PH_KEY_ANY = 4'd1;
    localparam logic [3:0] PH_KEY_OB  = 4'd2;
    localparam logic [3:0] PH_KEY_B   = 4'd3;
    localparam logic [3:0] PH_D_EQ    = 4'd4;
    localparam logic [3:0] PH_D_NUM   = 4'd5;
    localparam logic [3:0] PH_O_EQ    = 4'd6;
    localparam logic [3:0] PH_O_DIG   = 4'd7;
    localparam logic [3:0] PH_O_SKIP  = 4'd8;
    localparam logic [3:0] PH_B_EQ    = 4'd9;
    localparam logic [3:0] PH_B_NUM   = 4'd10;
    localparam logic [3:0] PH_N_NUM   = 4'd11;
    localparam logic [3:0] PH_N_SHARP = 4'd12;
    localparam logic [3:0] PH_N_DOT   = 4'd13;
    localparam logic [3:0] PH_N_SCALE = 4'd14;
    localparam logic [3:0] PH_N_TAIL  = 4'd15;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [4:0] DIV_STEPS = 5'd18;

    logic [1:0]  ctl_reg, ctl_next;
    logic [3:0]  phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [15:0] def_len_reg, def_len_next;
    logic [3:0]  def_oct_reg, def_oct_next;
    logic [17:0] whole_reg, whole_next;
    logic [3:0]  semi_reg, semi_next;
    logic [3:0]  oct_reg, oct_next;
    logic [18:0] len_reg, len_next;
    logic        zt_reg, zt_next;
    logic        emit_reg, emit_next;
    logic        last_reg, last_next;
    logic        div_note_reg, div_note_next;
    logic [16:0] rem_reg, rem_next;
    logic [17:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    note_word_t  out_word_reg, out_word_next;

    logic [7:0]  c;
    logic        is_dig;
    logic [3:0]  dval;
    logic        key_phase;
    logic [15:0] acc_src;
    logic [19:0] acc_prod;
    logic [15:0] acc_add;
    logic [15:0] note_n;
    logic        do_note;
    logic        comma_emit;
    logic        accept;
    logic        out_free;
    logic [16:0] rem_sh;
    logic        rem_ge;
    logic [16:0] rem_new;
    logic [17:0] quo_new;

    assign accept   = item_valid && !item_stall && (ctl_reg == S_IDLE);
    assign out_free = !out_valid_reg || !note_stall;

    assign c         = item_word.char_code;
    assign is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dval      = c[3:0];
    assign key_phase = (phase_reg == PH_KEY_ANY) || (phase_reg == PH_KEY_OB)
                       || (phase_reg == PH_KEY_B);
    assign acc_src   = key_phase ? 16'd0 : accum_reg;
    assign acc_prod  = {4'd0, acc_src} * 20'd10 + {16'd0, dval};
    assign acc_add   = (acc_prod > ACCUM_MAX) ? ACCUM_MAX[15:0] : acc_prod[15:0];
    assign note_n    = (acc_src != 16'd0) ? acc_src
                     : ((def_len_reg != 16'd0) ? def_len_reg : LEN_DEFAULT);

    assign rem_sh  = {rem_reg[15:0], quo_reg[17]};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = rem_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    assign quo_new = {quo_reg[16:0], rem_ge};

    always_comb
    begin
        ctl_next       = ctl_reg;
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        def_len_next   = def_len_reg;
        def_oct_next   = def_oct_reg;
        whole_next     = whole_reg;
        semi_next      = semi_reg;
        oct_next       = oct_reg;
        len_next       = len_reg;
        zt_next        = zt_reg;
        emit_next      = emit_reg;
        last_next      = last_reg;
        div_note_next  = div_note_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && note_stall;
        out_word_next  = out_word_reg;
        do_note        = 1'b0;
        comma_emit     = 1'b0;

        unique case (ctl_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl_next = S_FIN;
                    rem_next = 17'd0;
                    cnt_next = 5'd0;
                    unique case (phase_reg) inside
                        PH_NAME:
                        begin
                            if (c == CH_COLON)
                            begin
                                phase_next = PH_KEY_ANY;
                            end
                        end
                        PH_KEY_ANY, PH_KEY_OB, PH_KEY_B:
                        begin
                            if (c == CH_LC_D && phase_reg == PH_KEY_ANY)
                            begin
                                phase_next = PH_D_EQ;
                            end
                            else if (c == CH_LC_O && phase_reg != PH_KEY_B)
                            begin
                                phase_next = PH_O_EQ;
                            end
                            else if (c == CH_LC_B)
                            begin
                                phase_next = PH_B_EQ;
                            end
                            else
                            begin
                                zt_next    = 1'b0;
                                whole_next = WHOLE_DEFAULT;
                                accum_next = 16'd0;
                                phase_next = PH_N_NUM;
                                do_note    = 1'b1;
                            end
                        end
                        PH_D_EQ:
                        begin
                            accum_next = 16'd0;
                            phase_next = PH_D_NUM;
                        end
                        PH_D_NUM:
                        begin
                            if (is_dig)
                            begin
                                accum_next = acc_add;
                            end
                            else
                            begin
                                if (accum_reg != 16'd0)
                                begin
                                    def_len_next = accum_reg;
                                end
                                accum_next = 16'd0;
                                phase_next = PH_KEY_OB;
                            end
                        end
                        PH_O_EQ:
                        begin
                            phase_next = PH_O_DIG;
                        end
                        PH_O_DIG:
                        begin
                            if (c >= CH_THREE && c <= CH_SEVEN)
                            begin
                                def_oct_next = dval;
                            end
                            phase_next = PH_O_SKIP;
                        end
                        PH_O_SKIP:
                        begin
                            phase_next = PH_KEY_B;
                        end
                        PH_B_EQ:
                        begin
                            accum_next = 16'd0;
                            phase_next = PH_B_NUM;
                        end
                        PH_B_NUM:
                        begin
                            if (is_dig)
                            begin
                                accum_next = acc_add;
                            end
                            else
                            begin
                                if (accum_reg == 16'd0)
                                begin
                                    zt_next    = 1'b1;
                                    whole_next = 18'd0;
                                end
                                else
                                begin
                                    zt_next       = 1'b0;
                                    ctl_next      = S_DIV;
                                    div_note_next = 1'b0;
                                    quo_next      = WHOLE_DIVIDEND;
                                    dvs_next      = accum_reg;
                                end
                                accum_next = 16'd0;
                                phase_next = PH_N_NUM;
                            end
                        end
                        PH_N_NUM:
                        begin
                            do_note = 1'b1;
                        end
                        default:
                        begin
                            if (c == CH_COMMA)
                            begin
                                comma_emit = 1'b1;
                                accum_next = 16'd0;
                                phase_next = PH_N_NUM;
                            end
                            else if (c == CH_SHARP && phase_reg == PH_N_SHARP)
                            begin
                                semi_next  = semi_reg + 4'd1;
                                phase_next = PH_N_DOT;
                            end
                            else if (c == CH_DOT && (phase_reg == PH_N_SHARP
                                                     || phase_reg == PH_N_DOT))
                            begin
                                len_next   = len_reg + {1'b0, len_reg[18:1]};
                                phase_next = PH_N_SCALE;
                            end
                            else if (is_dig && phase_reg != PH_N_TAIL)
                            begin
                                oct_next   = dval;
                                phase_next = PH_N_TAIL;
                            end
                            else
                            begin
                                phase_next = PH_N_TAIL;
                            end
                        end
                    endcase

                    if (do_note)
                    begin
                        if (is_dig)
                        begin
                            accum_next = acc_add;
                        end
                        else
                        begin
                            semi_next     = letter_code(c);
                            oct_next      = def_oct_reg;
                            accum_next    = 16'd0;
                            phase_next    = PH_N_SHARP;
                            ctl_next      = S_DIV;
                            div_note_next = 1'b1;
                            quo_next      = whole_next;
                            dvs_next      = note_n;
                        end
                    end

                    last_next = item_word.end_of_text;
                    emit_next = comma_emit
                                || (item_word.end_of_text && (phase_next >= PH_N_SHARP));
                end
            end
            S_DIV:
            begin
                rem_next = rem_new;
                quo_next = quo_new;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_STEPS - 5'd1)
                begin
                    ctl_next = S_FIN;
                    if (div_note_reg)
                    begin
                        len_next = {1'b0, quo_new};
                    end
                    else
                    begin
                        whole_next = {quo_new[15:0], 2'b00};
                    end
                end
            end
            S_FIN:
            begin
                if (!emit_reg || out_free)
                begin
                    ctl_next = S_IDLE;
                    if (emit_reg)
                    begin
                        out_valid_next            = 1'b1;
                        out_word_next.semitone    = semi_reg;
                        out_word_next.octave      = oct_reg + OCT_OFFSET;
                        out_word_next.duration_ms = len_reg;
                        out_word_next.tempo_error = zt_reg;
                        out_word_next.last_note   = last_reg;
                    end
                    if (last_reg)
                    begin
                        phase_next   = PH_NAME;
                        accum_next   = 16'd0;
                        def_len_next = LEN_DEFAULT;
                        def_oct_next = OCT_DEFAULT;
                        whole_next   = 18'd0;
                        semi_next    = 4'd0;
                        oct_next     = 4'd0;
                        len_next     = 19'd0;
                        zt_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                ctl_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= S_IDLE;
            phase_reg     <= PH_NAME;
            accum_reg     <= 16'd0;
            def_len_reg   <= LEN_DEFAULT;
            def_oct_reg   <= OCT_DEFAULT;
            whole_reg     <= 18'd0;
            semi_reg      <= 4'd0;
            oct_reg       <= 4'd0;
            len_reg       <= 19'd0;
            zt_reg        <= 1'b0;
            emit_reg      <= 1'b0;
            last_reg      <= 1'b0;
            div_note_reg  <= 1'b0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            def_len_reg   <= def_len_next;
            def_oct_reg   <= def_oct_next;
            whole_reg     <= whole_next;
            semi_reg      <= semi_next;
            oct_reg       <= oct_next;
            len_reg       <= len_next;
            zt_reg        <= zt_next;
            emit_reg      <= emit_next;
            last_reg      <= last_next;
            div_note_reg  <= div_note_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        out_word_reg <= out_word_next;
    end

    assign item_stall = (ctl_reg != S_IDLE);
    assign note_valid = out_valid_reg;
    assign note_word  = out_word_reg;

`ifndef NO_ASSERTIONS
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == S_DIV) |-> (cnt_reg < DIV_STEPS))
        else $error("divider step count out of range");

    a_zero_tempo: assert property (@(posedge clk) disable iff (!rst_n)
        zt_reg |-> (whole_reg == 18'd0))
        else $error("zero tempo with nonzero whole note");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(ctl_reg) == S_FIN))
        else $error("note word loaded outside finish step");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == S_DIV && cnt_reg == DIV_STEPS - 5'd1) |=> (ctl_reg == S_FIN))
        else $error("divider did not hand off to finish step");
`endif

endmodule
